// File: rtl/length_prefixed_deframer_core_assert.svh
// assertion macros for the length-prefixed deframer
`ifndef LENGTH_PREFIXED_DEFRAMER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpd assertion failed");

// next-cycle implication, disabled during reset
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpd assertion failed");

`endif

// File: rtl/lpd_pkg.sv
`timescale 1ns / 1ps

package lpd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 32;

  typedef struct packed {
    logic            done;
    logic [LenW-1:0] len;
  } hdr_t;

endpackage

// File: rtl/lpd_hdr.sv
`timescale 1ns / 1ps

module lpd_hdr #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       byte_en_i,
  input  logic [lpd_pkg::ByteW-1:0]  data_byte_i,
  output lpd_pkg::hdr_t              hdr_o
);
  import lpd_pkg::*;

  localparam int unsigned CntW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

  logic [CntW-1:0] pos_q, pos_d;
  logic [LenW-1:0] acc_q, acc_d, acc_new;
  logic [2:0]      pos_ext;
  logic            last_pos;

  assign pos_ext  = 3'(pos_q);
  assign last_pos = (pos_q == CntW'(HEADER_BYTES - 1));

  always_comb begin
    acc_new = acc_q;
    if (!pos_ext[2]) begin
      acc_new = acc_q | (LenW'(data_byte_i) << {pos_ext[1:0], 3'b000});
    end else if (data_byte_i != '0) begin
      acc_new = '1;
    end
  end

  always_comb begin
    pos_d = pos_q;
    acc_d = acc_q;
    if (byte_en_i) begin
      if (last_pos) begin
        pos_d = '0;
        acc_d = '0;
      end else begin
        pos_d = pos_q + CntW'(1);
        acc_d = acc_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      acc_q <= '0;
    end else begin
      pos_q <= pos_d;
      acc_q <= acc_d;
    end
  end

  assign hdr_o.done = byte_en_i && last_pos;
  assign hdr_o.len  = acc_new;

endmodule

// File: rtl/length_prefixed_deframer_core.sv
// channel  | handshake                | payload
// ---------+--------------------------+---------------------------------
// in       | in_valid_i / in_ready_o  | data_byte_i
// out      | out_valid_o / out_ready_i| payload_byte_o, last_of_frame_o
//
// one stream byte per cycle while in_ready_o is high; a payload byte appears at the
// output in the cycle after its transfer, held in the output register
// header bytes are taken even while the output register is stalled
// payload bytes wait only when the output register is full and not taken
// reset clears the header counter, length and remaining count: awaits a header
`timescale 1ns / 1ps
`include "length_prefixed_deframer_core_assert.svh"

module length_prefixed_deframer_core #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lpd_pkg::ByteW-1:0] data_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lpd_pkg::ByteW-1:0] payload_byte_o,
  output logic                      last_of_frame_o
);
  import lpd_pkg::*;

  logic [LenW-1:0]  rem_q, rem_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] payload_q;
  logic             last_q;
  logic             streaming, in_fire, load;
  hdr_t             hdr;

  assign streaming  = (rem_q != '0);
  assign in_ready_o = !streaming || !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign load       = in_fire && streaming;

  lpd_hdr #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_hdr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_en_i  (in_fire && !streaming),
    .data_byte_i(data_byte_i),
    .hdr_o      (hdr)
  );

  always_comb begin
    rem_d = rem_q;
    if (load) begin
      rem_d = rem_q - LenW'(1);
    end else if (hdr.done) begin
      rem_d = hdr.len;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      payload_q <= data_byte_i;
      last_q    <= (rem_q == LenW'(1));
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = payload_q;
  assign last_of_frame_o = last_q;

  `LPD_ASSERT_NEXT(a_last_marked, clk_i, rst_ni, load && (rem_q == LenW'(1)), out_valid_o && last_of_frame_o)
  `LPD_ASSERT_NEXT(a_payload_shown, clk_i, rst_ni, load, out_valid_o && (payload_byte_o == $past(data_byte_i)))
  `LPD_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i && streaming)

endmodule
